// ===== rtl/core/apfh_pkg.sv =====
package apfh_pkg;

   // Field and datapath widths
   localparam int RAW_W      = 16;
   localparam int CHAN_W     = 20;
   localparam int TAP_W      = 8;
   localparam int PROD_W     = 24;   // 16 x 8 signed product
   localparam int PART_W     = 26;   // sum of four products
   localparam int SUM_W      = 28;   // sum of up to sixteen products
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 104;

   // Register reset values
   localparam logic [14:0]        RST_THRESHOLD  = 15'd0;
   localparam logic [14:0]        RST_STEP_COUNT = 15'd10;
   localparam logic signed [15:0] RST_PED_INIT   = 16'sd1000;
   localparam logic [63:0]        RST_TAPS_LOW   = 64'd940138555614036994;
   localparam logic [63:0]        RST_TAPS_HIGH  = 64'd145247715268955149;
   localparam logic [3:0]         RST_FIR_SHIFT  = 4'd6;

   // Register map, one 64-bit register every 8 bytes
   typedef enum logic [2:0] {
      REG_THRESHOLD  = 3'd0,
      REG_STEP_COUNT = 3'd1,
      REG_PED_INIT   = 3'd2,
      REG_TAPS_LOW   = 3'd3,
      REG_TAPS_HIGH  = 3'd4,
      REG_FIR_SHIFT  = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [14:0]        threshold;
      logic [14:0]        step_count;
      logic signed [15:0] ped_init;
      logic [63:0]        taps_low;
      logic [63:0]        taps_high;
      logic [3:0]         fir_shift;
   } cfg_type;

   // Per-sample control carried alongside the filter pipeline
   typedef struct packed {
      logic              last;
      logic              idx_nz;
      logic [15:0]       start;
      logic [CHAN_W-1:0] channel;
   } item_ctrl_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic [15:0]        start;
      logic signed [31:0] charge_sum;
      logic [15:0]        duration;
      logic signed [15:0] peak;
   } hit_type;

   // Tap j as a signed byte: taps 0..7 in the low word, 8..15 in the high word
   function automatic logic signed [TAP_W-1:0] tap_at(input logic [63:0] lo,
                                                      input logic [63:0] hi,
                                                      input logic [3:0]  j);
      logic [63:0] w;
      w = j[3] ? hi : lo;
      return $signed(w[{j[2:0], 3'b000} +: TAP_W]);
   endfunction

endpackage

// ===== rtl/core/apfh_csr.sv =====
module apfh_csr
   import apfh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // Register writes on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold  <= RST_THRESHOLD;
         cfg_ff.step_count <= RST_STEP_COUNT;
         cfg_ff.ped_init   <= RST_PED_INIT;
         cfg_ff.taps_low   <= RST_TAPS_LOW;
         cfg_ff.taps_high  <= RST_TAPS_HIGH;
         cfg_ff.fir_shift  <= RST_FIR_SHIFT;
      end else if (wr_en) begin
         case (reg_sel)
            REG_THRESHOLD:  cfg_ff.threshold  <= csr_pwdata[14:0];
            REG_STEP_COUNT: cfg_ff.step_count <= csr_pwdata[14:0];
            REG_PED_INIT:   cfg_ff.ped_init   <= $signed(csr_pwdata[15:0]);
            REG_TAPS_LOW:   cfg_ff.taps_low   <= csr_pwdata;
            REG_TAPS_HIGH:  cfg_ff.taps_high  <= csr_pwdata;
            REG_FIR_SHIFT:  cfg_ff.fir_shift  <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_sel)
         REG_THRESHOLD:  csr_prdata = {49'd0, cfg_ff.threshold};
         REG_STEP_COUNT: csr_prdata = {49'd0, cfg_ff.step_count};
         REG_PED_INIT:   csr_prdata = {48'd0, cfg_ff.ped_init};
         REG_TAPS_LOW:   csr_prdata = cfg_ff.taps_low;
         REG_TAPS_HIGH:  csr_prdata = cfg_ff.taps_high;
         REG_FIR_SHIFT:  csr_prdata = {60'd0, cfg_ff.fir_shift};
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/apfh_fir.sv =====
module apfh_fir
   import apfh_pkg::*;
#(
   parameter int NUM_TAPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic                    in_first,
   input  logic signed [RAW_W-1:0] in_pedsub,
   input  cfg_type                 cfg,
   output logic signed [RAW_W-1:0] filt
);

   localparam int HIST_LEN   = (NUM_TAPS > 1) ? NUM_TAPS - 1 : 1;
   localparam int NUM_GROUPS = (NUM_TAPS + 3) / 4;
   localparam int PAD_TAPS   = NUM_GROUPS * 4;

   logic signed [RAW_W-1:0]  hist_ff [HIST_LEN];
   logic signed [RAW_W-1:0]  opnd    [PAD_TAPS];
   logic signed [PROD_W-1:0] prod_in [PAD_TAPS];
   logic signed [PROD_W-1:0] prod_ff [PAD_TAPS];
   logic signed [PART_W-1:0] part_in [NUM_GROUPS];
   logic signed [PART_W-1:0] part_ff [NUM_GROUPS];
   logic signed [SUM_W-1:0]  total_in;
   logic signed [SUM_W-1:0]  shifted;
   logic signed [RAW_W-1:0]  filt_ff;

   // Tap operands; a first sample stands in for the whole history
   always_comb begin
      for (int j = 0; j < PAD_TAPS; j++) begin
         if (j == 0) begin
            opnd[j] = in_pedsub;
         end else if (j < NUM_TAPS) begin
            opnd[j] = in_first ? in_pedsub : hist_ff[j-1];
         end else begin
            opnd[j] = '0;
         end
         prod_in[j] = opnd[j] * tap_at(cfg.taps_low, cfg.taps_high, 4'(j));
      end
   end

   // Delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HIST_LEN; k++) hist_ff[k] <= '0;
      end else if (adv && in_valid) begin
         hist_ff[0] <= in_pedsub;
         for (int k = 1; k < HIST_LEN; k++)
            hist_ff[k] <= in_first ? in_pedsub : hist_ff[k-1];
      end
   end

   // Adder tree: groups of four, then the group sums
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         part_in[g] = PART_W'(prod_ff[4*g]) + PART_W'(prod_ff[4*g+1])
                    + PART_W'(prod_ff[4*g+2]) + PART_W'(prod_ff[4*g+3]);
      end
      total_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) total_in = total_in + SUM_W'(part_ff[g]);
      shifted = total_in >>> cfg.fir_shift;
   end

   // Pipeline registers: products, group sums, filtered value
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         part_ff <= part_in;
         filt_ff <= shifted[RAW_W-1:0];
      end
   end

   assign filt = filt_ff;

endmodule

// ===== rtl/core/adc_pedestal_fir_hit_finder.sv =====
// ADC pedestal-subtracting FIR hit finder.
// req channel: one raw ADC sample per transfer; tuser marks the first sample of a
// waveform (restarts pedestal, filter history, sample index and hit state and
// latches the channel id), tlast marks its last sample. rsp channel: one
// transfer per finished hit, sent on the first tested sample that falls back
// to or below threshold.
// Throughput: one sample per clock while the result queue is not full.
// Pedestal tracking and hit tracking each close their feedback within their own
// registers; the 16-tap filter is a three-stage pipeline (products, partial sums,
// final sum and shift) in between. A hit reaches rsp through the input register,
// the pedestal stage, the three filter stages and the result queue, in that order,
// after the sample that closes it is transferred.
// Results collect in a two-entry queue, so samples keep flowing while one
// result waits; when both entries are full req_tready drops and the whole
// pipeline holds until rsp takes a result.
// Reset clears the pipeline, the queue, the delay line and the tracking state
// and loads the register defaults; no sample needs to be first after reset.
// Registers sit at byte addresses 8*i on the csr port, 64 bits wide; write
// them only while no samples are in flight.
module adc_pedestal_fir_hit_finder
   import apfh_pkg::*;
#(
   parameter int NUM_TAPS   = 16,
   parameter int INDEX_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // raw_sample[15:0], channel_id[35:16], zero pad
   input  logic                  req_tlast,
   input  logic                  req_tuser,   // first_of_waveform
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // hit_channel, hit_start, hit_charge_sum,
                                              // hit_duration, hit_peak, zero pad
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

   cfg_type cfg;
   logic    adv;

   apfh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------- input register ----------------
   logic                    v0_ff;
   logic signed [RAW_W-1:0] raw0_ff;
   logic [CHAN_W-1:0]       chan0_ff;
   logic                    first0_ff;
   logic                    last0_ff;

   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         raw0_ff   <= $signed(req_tdata[15:0]);
         chan0_ff  <= req_tdata[35:16];
         first0_ff <= req_tuser;
         last0_ff  <= req_tlast;
      end
   end

   // ---------------- pedestal stage ----------------
   logic signed [15:0]      med_ff, med_base, med_in;
   logic signed [16:0]      vote_ff, vote_base, vote_in;
   logic signed [17:0]      vote_sum, vote_lim;
   logic [INDEX_BITS-1:0]   idx_ff, idx_cur, idx_in;
   logic [CHAN_W-1:0]       chan_ff, chan_in;
   logic signed [RAW_W-1:0] pedsub_in;

   always_comb begin
      med_base  = first0_ff ? cfg.ped_init : med_ff;
      vote_base = first0_ff ? '0 : vote_ff;
      vote_lim  = $signed({3'b000, cfg.step_count});
      vote_sum  = 18'(vote_base)
                + ((raw0_ff > med_base) ? 18'sd1 : 18'sd0)
                - ((raw0_ff < med_base) ? 18'sd1 : 18'sd0);
      med_in  = med_base;
      vote_in = 17'(vote_sum);
      if (vote_sum > vote_lim) begin
         med_in  = med_base + 16'sd1;
         vote_in = '0;
      end else if (vote_sum < -vote_lim) begin
         med_in  = med_base - 16'sd1;
         vote_in = '0;
      end
      pedsub_in = raw0_ff - med_in;

      idx_cur = first0_ff ? '0 : idx_ff;
      idx_in  = (idx_cur == INDEX_MAX) ? idx_cur : idx_cur + 1'b1;
      chan_in = first0_ff ? chan0_ff : chan_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         med_ff  <= RST_PED_INIT;
         vote_ff <= '0;
         idx_ff  <= '0;
         chan_ff <= '0;
      end else if (adv && v0_ff) begin
         med_ff  <= med_in;
         vote_ff <= vote_in;
         idx_ff  <= idx_in;
         chan_ff <= chan_in;
      end
   end

   // Stage 1 register
   logic                    v1_ff;
   logic                    first1_ff;
   logic signed [RAW_W-1:0] pedsub1_ff;
   item_ctrl_type           ctrl1_ff, ctrl2_ff, ctrl3_ff, ctrl4_ff;
   logic                    v2_ff, v3_ff, v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         first1_ff        <= first0_ff;
         pedsub1_ff       <= pedsub_in;
         ctrl1_ff.last    <= last0_ff;
         ctrl1_ff.idx_nz  <= (idx_cur != '0);
         ctrl1_ff.start   <= 16'(idx_cur);
         ctrl1_ff.channel <= chan_in;
         ctrl2_ff         <= ctrl1_ff;
         ctrl3_ff         <= ctrl2_ff;
         ctrl4_ff         <= ctrl3_ff;
      end
   end

   // ---------------- filter ----------------
   logic signed [RAW_W-1:0] filt4;

   apfh_fir #(
      .NUM_TAPS (NUM_TAPS)
   ) u_fir (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v1_ff),
      .in_first  (first1_ff),
      .in_pedsub (pedsub1_ff),
      .cfg       (cfg),
      .filt      (filt4)
   );

   // ---------------- hit tracking ----------------
   logic               prev_ff, prev_in;
   logic [15:0]        ostart_ff, ostart_in;
   logic signed [31:0] osum_ff, osum_in;
   logic [15:0]        ocount_ff, ocount_in;
   logic signed [15:0] opeak_ff, opeak_in;
   logic signed [32:0] sum_ext;
   logic               over;
   logic               push;
   hit_type            hit;

   always_comb begin
      over      = filt4 > $signed({1'b0, cfg.threshold});
      sum_ext   = 33'(osum_ff) + 33'(filt4);
      prev_in   = prev_ff;
      ostart_in = ostart_ff;
      osum_in   = osum_ff;
      ocount_in = ocount_ff;
      opeak_in  = opeak_ff;
      push      = 1'b0;
      if (ctrl4_ff.last || !ctrl4_ff.idx_nz) begin
         prev_in = 1'b0;
      end else begin
         if (over && !prev_ff) begin
            ostart_in = ctrl4_ff.start;
            osum_in   = 32'(filt4);
            ocount_in = 16'd1;
            opeak_in  = filt4;
         end else if (over) begin
            // saturate the charge sum on signed overflow
            if (sum_ext[32] != sum_ext[31]) begin
               osum_in = sum_ext[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               osum_in = sum_ext[31:0];
            end
            if (ocount_ff != 16'hFFFF) ocount_in = ocount_ff + 16'd1;
            if (filt4 > opeak_ff) opeak_in = filt4;
         end else if (prev_ff) begin
            push = v4_ff & adv;
         end
         prev_in = over;
      end
      hit.channel    = ctrl4_ff.channel;
      hit.start      = ostart_ff;
      hit.charge_sum = osum_ff;
      hit.duration   = ocount_ff;
      hit.peak       = opeak_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 1'b0;
      end else if (adv && v4_ff) begin
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v4_ff) begin
         ostart_ff <= ostart_in;
         osum_ff   <= osum_in;
         ocount_ff <= ocount_in;
         opeak_ff  <= opeak_in;
      end
   end

   // ---------------- result queue ----------------
   hit_type    q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;
   hit_type    q_head;

   assign adv        = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign q_head     = q_ff[rd_ptr_ff];
   assign rsp_tdata  = {4'd0, q_head.peak, q_head.duration, q_head.charge_sum,
                        q_head.start, q_head.channel};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= hit;
   end

   // ---------------- checks ----------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_push_tested: assert property (@(posedge clock) disable iff (reset)
      push |-> (v4_ff && !ctrl4_ff.last && ctrl4_ff.idx_nz && prev_ff && !over))
      else $error("hit sent from a sample that is not tested or not closing");

   a_stall_holds_median: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(med_ff) && $stable(vote_ff) && $stable(idx_ff)))
      else $error("pedestal state moved during a stall");

   a_first_vote: assert property (@(posedge clock) disable iff (reset)
      (adv && v0_ff && first0_ff) |=>
         (vote_ff == 17'sd0 || vote_ff == 17'sd1 || vote_ff == -17'sd1))
      else $error("vote not restarted at the first sample");

endmodule
